// ----- rtl/pfsb_pkg.sv -----
// ----------------------------------------------------------------------------
// pfsb_pkg
// shared types and constants for the prime factor shape builder
// ----------------------------------------------------------------------------
`default_nettype none

package pfsb_pkg;

  localparam int unsigned FieldW       = 16;
  localparam int unsigned MaxFactors   = 15;
  localparam int unsigned NfW          = 4;
  localparam int unsigned NumDims      = 3;
  localparam int unsigned FirstDivisor = 2;

  typedef struct packed {
    logic              kind;
    logic [FieldW-1:0] factor;
    logic [FieldW-1:0] dim_one;
    logic [FieldW-1:0] dim_two;
    logic [FieldW-1:0] dim_three;
    logic [1:0]        dim_count;
    logic              last;
  } item_t;

  localparam logic KindFactor = 1'b0;
  localparam logic KindShape  = 1'b1;

endpackage

`default_nettype wire

// ----- rtl/pfsb_div.sv -----
// ----------------------------------------------------------------------------
// pfsb_div
// iterative restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module pfsb_div #(
  parameter int unsigned W = 16
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         start_i,
  input  wire logic [W-1:0] dividend_i,
  input  wire logic [W-1:0] divisor_i,
  output logic              done_o,
  output logic [W-1:0]      quot_o,
  output logic [W-1:0]      rem_o
);

  localparam int unsigned CW = $clog2(W + 1);

  logic [W-1:0]  r_q, r_d, q_q, q_d, d_q;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          run_q, run_d, done_q, done_d;
  logic [W:0]    rs, diff;
  logic          ge;

  always_comb begin
    rs   = {r_q, q_q[W-1]};
    diff = rs - {1'b0, d_q};
    ge   = ~diff[W];
    r_d  = r_q;
    q_d  = q_q;
    cnt_d  = cnt_q;
    run_d  = run_q;
    done_d = 1'b0;
    if (start_i) begin
      r_d   = '0;
      q_d   = dividend_i;
      cnt_d = '0;
      run_d = 1'b1;
    end else if (run_q) begin
      r_d   = ge ? diff[W-1:0] : rs[W-1:0];
      q_d   = {q_q[W-2:0], ge};
      cnt_d = cnt_q + CW'(1);
      if (cnt_q == CW'(W - 1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    r_q <= r_d;
    q_q <= q_d;
    if (start_i) begin
      d_q <= divisor_i;
    end
  end

  assign done_o = done_q;
  assign quot_o = q_q;
  assign rem_o  = r_q;

endmodule

`default_nettype wire

// ----- rtl/pfsb_out_reg.sv -----
// ----------------------------------------------------------------------------
// pfsb_out_reg
// output register holding one result word until the receiver takes it
// ----------------------------------------------------------------------------
`default_nettype none

module pfsb_out_reg (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           load_i,
  input  wire pfsb_pkg::item_t item_i,
  input  wire logic           ready_i,
  output logic                valid_o,
  output logic                free_o,
  output pfsb_pkg::item_t     item_o
);

  import pfsb_pkg::*;

  logic  valid_q, valid_d;
  item_t item_q;

  assign free_o = ~valid_q | ready_i;

  always_comb begin
    valid_d = valid_q;
    if (ready_i) begin
      valid_d = 1'b0;
    end
    if (load_i) begin
      valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

`default_nettype wire

// ----- rtl/prime_factor_shape_builder.sv -----
// ----------------------------------------------------------------------------
// prime_factor_shape_builder
// trial division factoring with a round-robin three dimension shape
// ----------------------------------------------------------------------------
// input channel: in_valid_i / in_ready_o with value_i, one value per word.
// output channel: out_valid_o / out_ready_i, one word per prime factor in
// ascending order (kind 0), then one shape word (kind 1, last 1).
// in_ready_o is high only while the sequencer is idle; one value is
// worked on at a time.
// each candidate divisor costs a square compare, a divider start and one
// pass of the shared bit-serial divider, which is min(VALUE_WIDTH, 16) bits
// wide; each factor found adds an emission and a further divider pass at
// the same candidate. a 16 bit value runs at most 254 candidates; zero
// skips trial division and goes straight to its shape word.
// a stalled receiver holds the output register; the sequencer waits at
// its next emission and resumes when the register frees.
// reset clears the sequencer, the divider control and the output valid.
// ----------------------------------------------------------------------------
`default_nettype none

module prime_factor_shape_builder #(
  parameter int unsigned VALUE_WIDTH = 16
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire logic [pfsb_pkg::FieldW-1:0] value_i,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic                             kind_o,
  output logic [pfsb_pkg::FieldW-1:0]      factor_o,
  output logic [pfsb_pkg::FieldW-1:0]      dim_one_o,
  output logic [pfsb_pkg::FieldW-1:0]      dim_two_o,
  output logic [pfsb_pkg::FieldW-1:0]      dim_three_o,
  output logic [1:0]                       dim_count_o,
  output logic                             last_o
);

  import pfsb_pkg::*;

  localparam int unsigned VW = (VALUE_WIDTH < FieldW) ? VALUE_WIDTH : FieldW;
  localparam int unsigned PW = (VW + 1) / 2 + 1;

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StCheck = 3'd1;
  localparam logic [2:0] StInner = 3'd2;
  localparam logic [2:0] StDiv   = 3'd3;
  localparam logic [2:0] StTail  = 3'd4;
  localparam logic [2:0] StEmit  = 3'd5;
  localparam logic [2:0] StShape = 3'd6;

  logic [2:0]     state_q, state_d, ret_q, ret_d;
  logic [VW-1:0]  rem_q, rem_d, fac_q, fac_d;
  logic [VW-1:0]  dim0_q, dim0_d, dim1_q, dim1_d, dim2_q, dim2_d;
  logic [PW-1:0]  p_q, p_d;
  logic [NfW-1:0] nf_q, nf_d;
  logic [1:0]     idx_q, idx_d;

  logic [2*PW-1:0] sq;
  logic [VW-1:0]   dsel, prod, val;
  logic [2*VW-1:0] prod_full;
  logic            nf_room;

  logic          div_start, div_done;
  logic [VW-1:0] div_quot, div_rem;

  logic  out_load, out_free;
  item_t out_item, load_item;

  pfsb_div #(.W(VW)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (rem_q),
    .divisor_i  (VW'(p_q)),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  pfsb_out_reg u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (out_load),
    .item_i  (load_item),
    .ready_i (out_ready_i),
    .valid_o (out_valid_o),
    .free_o  (out_free),
    .item_o  (out_item)
  );

  assign val       = value_i[VW-1:0];
  assign sq        = p_q * p_q;
  assign nf_room   = nf_q < NfW'(MaxFactors);
  assign div_start = (state_q == StInner) && nf_room;

  always_comb begin
    unique case (idx_q)
      2'd0:    dsel = dim0_q;
      2'd1:    dsel = dim1_q;
      default: dsel = dim2_q;
    endcase
  end

  assign prod_full = dsel * fac_q;
  assign prod      = prod_full[VW-1:0];

  always_comb begin
    state_d   = state_q;
    ret_d     = ret_q;
    rem_d     = rem_q;
    fac_d     = fac_q;
    dim0_d    = dim0_q;
    dim1_d    = dim1_q;
    dim2_d    = dim2_q;
    p_d       = p_q;
    nf_d      = nf_q;
    idx_d     = idx_q;
    out_load  = 1'b0;
    load_item = '0;

    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          rem_d  = val;
          p_d    = PW'(FirstDivisor);
          idx_d  = 2'd0;
          dim0_d = VW'(1);
          dim1_d = VW'(1);
          dim2_d = VW'(1);
          if (val == '0) begin
            // zero reports all three unit dims
            nf_d    = NfW'(NumDims);
            state_d = StShape;
          end else begin
            nf_d    = '0;
            state_d = StCheck;
          end
        end
      end
      StCheck: begin
        state_d = (sq <= (2*PW)'(rem_q)) ? StInner : StTail;
      end
      StInner: begin
        if (nf_room) begin
          state_d = StDiv;
        end else begin
          p_d     = p_q + PW'(1);
          state_d = StCheck;
        end
      end
      StDiv: begin
        if (div_done) begin
          if (div_rem == '0) begin
            fac_d   = VW'(p_q);
            rem_d   = div_quot;
            ret_d   = StInner;
            state_d = StEmit;
          end else begin
            p_d     = p_q + PW'(1);
            state_d = StCheck;
          end
        end
      end
      StTail: begin
        if (nf_room && ((rem_q > VW'(1)) || (nf_q == '0))) begin
          fac_d   = rem_q;
          ret_d   = StShape;
          state_d = StEmit;
        end else begin
          state_d = StShape;
        end
      end
      StEmit: begin
        if (out_free) begin
          out_load         = 1'b1;
          load_item.kind   = KindFactor;
          load_item.factor = FieldW'(fac_q);
          unique case (idx_q)
            2'd0:    dim0_d = prod;
            2'd1:    dim1_d = prod;
            default: dim2_d = prod;
          endcase
          idx_d   = (idx_q == 2'd2) ? 2'd0 : idx_q + 2'd1;
          nf_d    = nf_q + NfW'(1);
          state_d = ret_q;
        end
      end
      StShape: begin
        if (out_free) begin
          out_load            = 1'b1;
          load_item.kind      = KindShape;
          load_item.dim_one   = FieldW'(dim0_q);
          load_item.dim_two   = FieldW'(dim1_q);
          load_item.dim_three = FieldW'(dim2_q);
          load_item.dim_count = (nf_q >= NfW'(NumDims)) ? 2'(NumDims) : nf_q[1:0];
          load_item.last      = 1'b1;
          state_d             = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      ret_q   <= StIdle;
      nf_q    <= '0;
      idx_q   <= '0;
      p_q     <= PW'(FirstDivisor);
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
      nf_q    <= nf_d;
      idx_q   <= idx_d;
      p_q     <= p_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    fac_q  <= fac_d;
    dim0_q <= dim0_d;
    dim1_q <= dim1_d;
    dim2_q <= dim2_d;
  end

  assign in_ready_o  = (state_q == StIdle);
  assign kind_o      = out_item.kind;
  assign factor_o    = out_item.factor;
  assign dim_one_o   = out_item.dim_one;
  assign dim_two_o   = out_item.dim_two;
  assign dim_three_o = out_item.dim_three;
  assign dim_count_o = out_item.dim_count;
  assign last_o      = out_item.last;

endmodule

`default_nettype wire
